// ----- hw/rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
// pfa_pkg: shared types, sizes and codes of the page frame allocator
// depends on nothing; used by pfa_frame_mem, page_frame_allocator, pfa_checker and the bench
package pfa_pkg;

  localparam int unsigned NUM_FRAMES  = 40;
  localparam int unsigned FRAME_UNITS = 5;

  // field widths fixed by the item format
  localparam int unsigned OwnerW  = 8;
  localparam int unsigned SizeW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FrameW  = 6;
  localparam int unsigned FillW   = 3;
  localparam int unsigned CountW  = 6;

  // internal widths
  localparam int unsigned IdxW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CntW  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned ProdW = $clog2(NUM_FRAMES * FRAME_UNITS + 1);
  localparam int unsigned CmpW  = (ProdW > SizeW) ? ProdW : SizeW;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_GRANT  = 2'd0,
    ST_REFUSE = 2'd1,
    ST_FREED  = 2'd2
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [OwnerW-1:0] proc_id;
    logic [SizeW-1:0]  proc_size;
  } pfa_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  frame_index;
    logic [FillW-1:0]   frame_fill;
    logic [CountW-1:0]  free_count;
    logic               last;
  } pfa_out_t;

  // write / clear request into the frame table
  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [IdxW-1:0]   addr;
    logic [OwnerW-1:0] owner;
  } pfa_mem_req_t;

endpackage

// ----- hw/rtl/pfa_frame_mem.sv -----
`timescale 1ns / 1ps
// pfa_frame_mem: frame owner memory plus per-frame occupied bits
// depends on pfa_pkg
module pfa_frame_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pfa_pkg::pfa_mem_req_t        req_i,
  input  logic                         rd_en_i,
  input  logic [pfa_pkg::IdxW-1:0]     rd_addr_i,
  output logic [pfa_pkg::OwnerW-1:0]   rd_owner_o,
  input  logic [pfa_pkg::IdxW-1:0]     chk_idx_i,
  output logic                         chk_used_o
);
  import pfa_pkg::*;

  logic [OwnerW-1:0]     owner_mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] used_q;
  logic [OwnerW-1:0]     rd_owner_q;

  // owner array, no reset: an entry only counts while its used bit is set
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      owner_mem[req_i.addr] <= req_i.owner;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_owner_q <= owner_mem[rd_addr_i];
    end
  end

  // used bit stands for a nonzero fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (req_i.wr) begin
      used_q[req_i.addr] <= 1'b1;
    end else if (req_i.clr) begin
      used_q[req_i.addr] <= 1'b0;
    end
  end

  assign rd_owner_o = rd_owner_q;
  assign chk_used_o = used_q[chk_idx_i];

endmodule

// ----- hw/rtl/page_frame_allocator.sv -----
`timescale 1ns / 1ps
// page_frame_allocator: first-fit frame allocator, top level
// depends on pfa_pkg and pfa_frame_mem
//
// usage
// - request channel (in_valid_i / in_ready_o / in_data_i): one item is an
//   allocate (proc_id, proc_size) or a free of all frames of proc_id
// - result channel (out_valid_o / out_ready_i / out_data_o): an allocate
//   gives one item per granted frame, lowest free frame first, the final
//   one with last set; a refusal, a zero-size allocate and a free give a
//   single item with last set
// - in_ready_o is high only while no request is in work; one request is
//   handled at a time by a sequencer that walks the frame table one entry
//   per cycle, an allocate walk pausing while a result is stalled
// - a new request is taken only once the final result of the last one is
//   registered; requests do not overlap
// - results leave through an output register; a receiver stall halts an
//   allocate walk, and a free waits after its walk, until it drains
// - reset: all frames free (used bits cleared at once), free count 40,
//   no result pending; ready as soon as reset is released
module page_frame_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfa_pkg::pfa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfa_pkg::pfa_out_t out_data_o
);
  import pfa_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_ALLOC  = 3'd2;
  localparam logic [2:0] S_FREE   = 3'd3;
  localparam logic [2:0] S_FDONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  pfa_in_t           req_q;
  logic [SizeW-1:0]  rem_q, rem_d;          // units still to place
  logic [CntW-1:0]   scan_q, scan_d;        // frame walk pointer
  logic              pend_q, pend_d;        // memory read in flight (free walk)
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [CntW-1:0]   free_q, free_d;        // free frame count
  logic              out_valid_q, out_valid_d;
  pfa_out_t          out_q, out_d;

  pfa_mem_req_t      mem_req;
  logic              rd_en;
  logic [OwnerW-1:0] rd_owner;
  logic [IdxW-1:0]   chk_idx;
  logic              chk_used;

  logic              slot_free;
  logic [CmpW-1:0]   cap_units;             // units that the free frames can hold
  logic              too_big;
  logic              last_frame;
  logic [FillW-1:0]  fill;

  assign slot_free = !out_valid_q || out_ready_i;

  // compare unit: need > free  <=>  size > free * FRAME_UNITS
  assign cap_units = CmpW'(ProdW'(free_q) * ProdW'(FRAME_UNITS));
  assign too_big   = CmpW'(req_q.proc_size) > cap_units;

  // last frame takes the remainder, or a full frame when it divides evenly
  assign last_frame = rem_q <= SizeW'(FRAME_UNITS);
  assign fill       = last_frame ? FillW'(rem_q) : FillW'(FRAME_UNITS);

  pfa_frame_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rd_en_i    (rd_en),
    .rd_addr_i  (scan_q[IdxW-1:0]),
    .rd_owner_o (rd_owner),
    .chk_idx_i  (chk_idx),
    .chk_used_o (chk_used)
  );

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    free_d      = free_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_req     = '0;
    rd_en       = 1'b0;
    chk_idx     = scan_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          scan_d  = '0;
          pend_d  = 1'b0;
          rem_d   = in_data_i.proc_size;
          state_d = (in_data_i.req_type == REQ_FREE) ? S_FREE : S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (slot_free) begin
          if (req_q.proc_id == '0 || too_big) begin
            out_valid_d = 1'b1;
            out_d       = '{status: ST_REFUSE, frame_index: '0, frame_fill: '0,
                            free_count: CountW'(free_q), last: 1'b1};
            state_d     = S_IDLE;
          end else if (req_q.proc_size == '0) begin
            out_valid_d = 1'b1;
            out_d       = '{status: ST_GRANT, frame_index: '0, frame_fill: '0,
                            free_count: CountW'(free_q), last: 1'b1};
            state_d     = S_IDLE;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end

      // one table entry per cycle while the result slot is free; enough free frames are known to exist
      S_ALLOC: begin
        if (slot_free) begin
          scan_d = scan_q + 1'b1;
          if (!chk_used) begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = scan_q[IdxW-1:0];
            mem_req.owner = req_q.proc_id;
            free_d        = free_q - 1'b1;
            rem_d         = rem_q - SizeW'(fill);
            out_valid_d   = 1'b1;
            out_d         = '{status: ST_GRANT,
                              frame_index: FrameW'(scan_q + 1'b1),
                              frame_fill: fill,
                              free_count: CountW'(free_q - 1'b1),
                              last: last_frame};
            if (last_frame) begin
              state_d = S_IDLE;
            end
          end
        end
      end

      // read owner of entry scan, compare entry read last cycle
      S_FREE: begin
        chk_idx = pend_idx_q;
        if (scan_q < CntW'(NUM_FRAMES)) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = scan_q[IdxW-1:0];
          scan_d     = scan_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && chk_used && rd_owner == req_q.proc_id) begin
          mem_req.clr  = 1'b1;
          mem_req.addr = pend_idx_q;
          if (free_q < CntW'(NUM_FRAMES)) begin
            free_d = free_q + 1'b1;
          end
        end
        if (!pend_q && scan_q >= CntW'(NUM_FRAMES)) begin
          state_d = S_FDONE;
        end
      end

      S_FDONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: ST_FREED, frame_index: '0, frame_fill: '0,
                          free_count: CountW'(free_q), last: 1'b1};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rem_q       <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      free_q      <= CntW'(NUM_FRAMES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/pfa_checker.sv -----
`timescale 1ns / 1ps
// pfa_checker: port-level checks of the page frame allocator, bound to the top
// depends on pfa_pkg and page_frame_allocator
module pfa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pfa_pkg::pfa_out_t out_data_o
);
  import pfa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request was taken");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.free_count <= CountW'(NUM_FRAMES))
    else $error("free count out of range");

  // a named frame is in range and holds something
  a_grant_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_index != '0 |->
      out_data_o.status == ST_GRANT &&
      out_data_o.frame_index <= FrameW'(NUM_FRAMES) &&
      out_data_o.frame_fill != '0 && out_data_o.frame_fill <= FillW'(FRAME_UNITS))
    else $error("bad granted frame");

  // refusal and free are single results naming no frame
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_REFUSE || out_data_o.status == ST_FREED) |->
      out_data_o.last && out_data_o.frame_index == '0 && out_data_o.frame_fill == '0)
    else $error("refuse or free result malformed");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- sim/tb_page_frame_allocator.sv -----
`timescale 1ns / 1ps
// tb_page_frame_allocator: self-checking bench for the first-fit frame allocator
// depends on pfa_pkg and page_frame_allocator; predicts every result item in a
// small frame ledger class and drives both valid / ready channels with random idling
module tb_page_frame_allocator;
  import pfa_pkg::*;

  // run shape
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned HOLD_AT      = 40;   // receiver holds off from here
  localparam int unsigned PAUSE_AT     = 70;   // sender waits for all results here
  localparam int unsigned QUIET_AT     = 85;   // no idling from here on
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 60;   // longer than a full free walk

  // ledger of frames: mirrors the owner / fill tables and owes result items
  class frame_ledger;
    bit [FillW-1:0]  fill_tbl[NUM_FRAMES];
    bit [OwnerW-1:0] owner_tbl[NUM_FRAMES];
    int unsigned     free_left;
    pfa_out_t        owed_q[$];
    int unsigned     errors;
    int unsigned     n_requests, n_results, n_frames, n_refused, n_freed, widest;

    function new();
      foreach (fill_tbl[i]) begin
        fill_tbl[i]  = '0;
        owner_tbl[i] = '0;
      end
      free_left = NUM_FRAMES;
    endfunction

    function void owe(status_e st, int unsigned idx, int unsigned fill, bit fin);
      pfa_out_t r;
      r.status      = st;
      r.frame_index = FrameW'(idx);
      r.frame_fill  = FillW'(fill);
      r.free_count  = CountW'(free_left);
      r.last        = fin;
      owed_q = {owed_q, r};
    endfunction

    // accepted request: update the tables and queue the items it causes
    function void note_request(pfa_in_t req);
      int unsigned need;
      int unsigned rem;
      int unsigned fill;
      int unsigned taken;
      n_requests++;
      if (req.req_type == REQ_FREE) begin
        foreach (fill_tbl[i]) begin
          if (fill_tbl[i] != 0 && owner_tbl[i] == req.proc_id) begin
            fill_tbl[i]  = '0;
            owner_tbl[i] = '0;
            if (free_left < NUM_FRAMES) free_left++;
          end
        end
        n_freed++;
        owe(ST_FREED, 0, 0, 1'b1);
        return;
      end
      need = req.proc_size / FRAME_UNITS;
      rem  = req.proc_size % FRAME_UNITS;
      if (rem != 0) need++;
      if (req.proc_id == 0 || need > free_left) begin
        n_refused++;
        owe(ST_REFUSE, 0, 0, 1'b1);
      end else if (need == 0) begin
        owe(ST_GRANT, 0, 0, 1'b1);
      end else begin
        taken = 0;
        for (int i = 0; i < NUM_FRAMES && need != 0; i++) begin
          if (fill_tbl[i] == 0) begin
            fill = (need == 1 && rem != 0) ? rem : FRAME_UNITS;
            fill_tbl[i]  = FillW'(fill);
            owner_tbl[i] = req.proc_id;
            free_left--;
            need--;
            taken++;
            owe(ST_GRANT, i + 1, fill, need == 0);
          end
        end
        n_frames += taken;
        if (taken > widest) widest = taken;
      end
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(pfa_out_t got);
      pfa_out_t want;
      n_results++;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none, actual %p", $time, got);
        return;
      end
      want = owed_q.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("frame_index", want.frame_index, got.frame_index);
      cmp_field("frame_fill", want.frame_fill, got.frame_fill);
      cmp_field("free_count", want.free_count, got.free_count);
      cmp_field("last", want.last, got.last);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  pfa_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  pfa_out_t out_data_o;

  // phase flags shared by sender and receiver
  bit quiet        = 1'b0;
  bit hold_results = 1'b0;

  frame_ledger ledger;
  bit [OwnerW-1:0] id_pool[6];

  always #10 clk_i = ~clk_i;

  page_frame_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // monitor: both handshakes seen at the same edge the block sees them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) ledger.note_request(in_data_i);
      if (out_valid_o && out_ready_i) ledger.check_result(out_data_o);
    end
  end

  // result side: random stall bursts, one long hold-off on request, none when quiet
  initial begin : result_side
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        // long stall so the block backs up and drops in_ready_o
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  function automatic pfa_in_t make_req(req_type_e kind, int unsigned id, int unsigned size);
    pfa_in_t r;
    r.req_type  = kind;
    r.proc_id   = OwnerW'(id);
    r.proc_size = SizeW'(size);
    return r;
  endfunction

  // mostly small sizes, a few up to the full 8-bit field
  function automatic int unsigned random_size();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 25);
    if (pick < 9) return $urandom_range(26, 100);
    return $urandom_range(101, 255);
  endfunction

  // well-formed traffic over a small set of live owners, plus some noise
  function automatic pfa_in_t random_request();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return make_req(REQ_ALLOC, id_pool[$urandom_range(0, 5)], random_size());
    if (roll < 85) return make_req(REQ_FREE, id_pool[$urandom_range(0, 5)], $urandom_range(0, 255));
    if (roll < 92) return make_req(REQ_ALLOC, $urandom_range(0, 255), $urandom_range(0, 255));
    return make_req(REQ_FREE, $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // offer one item, with an optional idle burst first; returns at the accepting edge
  task automatic send_request(input pfa_in_t item);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait until every owed item has come back; one edge first so
  // the monitor has noted the item accepted at the current edge
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : request_side
    pfa_in_t directed_q[$];
    ledger = new();
    foreach (id_pool[i]) id_pool[i] = OwnerW'($urandom_range(1, 255));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero size, owner zero, unknown owners, full memory, refusals,
    // repeated allocate, first-fit into holes, size field ignored on free
    directed_q = {directed_q, make_req(REQ_ALLOC, 1, 0)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 0, 7)};
    directed_q = {directed_q, make_req(REQ_FREE, 0, 0)};
    directed_q = {directed_q, make_req(REQ_FREE, 9, 255)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 255, 200)};   // takes every frame
    directed_q = {directed_q, make_req(REQ_ALLOC, 3, 1)};       // nothing left
    directed_q = {directed_q, make_req(REQ_ALLOC, 3, 0)};       // zero size still granted
    directed_q = {directed_q, make_req(REQ_FREE, 255, 0)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 255, 255)};   // beyond range, too large
    directed_q = {directed_q, make_req(REQ_ALLOC, 1, 7)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 2, 5)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 1, 13)};      // same owner again
    directed_q = {directed_q, make_req(REQ_FREE, 1, 0)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 170, 16)};    // fills the holes first
    directed_q = {directed_q, make_req(REQ_ALLOC, 85, 4)};
    directed_q = {directed_q, make_req(REQ_FREE, 2, 170)};
    directed_q = {directed_q, make_req(REQ_FREE, 170, 0)};
    directed_q = {directed_q, make_req(REQ_FREE, 85, 0)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 128, 195)};
    directed_q = {directed_q, make_req(REQ_ALLOC, 127, 10)};    // one frame short
    directed_q = {directed_q, make_req(REQ_ALLOC, 127, 5)};
    directed_q = {directed_q, make_req(REQ_FREE, 128, 0)};
    directed_q = {directed_q, make_req(REQ_FREE, 127, 0)};
    foreach (directed_q[i]) send_request(directed_q[i]);

    // random traffic with a long result stall, a full pause and a quiet tail
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_results = 1'b1;
      if (n == PAUSE_AT) drain_results();
      if (n == QUIET_AT) quiet = 1'b1;
      send_request(random_request());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d result items: %0d frames granted, %0d refusals,",
             ledger.n_requests, ledger.n_results, ledger.n_frames, ledger.n_refused);
    $display("%0d frees, widest allocation %0d frames", ledger.n_freed, ledger.widest);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout at %0t, %0d result items still owed", $time, ledger.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
